>>> design/prim_minimum_spanning_tree_core_macros.svh
// Assertion helpers used by pmst_dpath.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PMST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmst assertion failed");

// Check that cons holds in the cycle after ante.
`define PMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmst assertion failed");

`endif

>>> design/pmst_pkg.sv
`default_nettype none
package pmst_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int WEIGHT_BITS  = 16;
   localparam int VERT_BITS    = 7;
   localparam int FUNC_BITS    = 2;
   localparam int IDX_BITS     = $clog2(MAX_VERTICES);
   localparam int ADDR_BITS    = 2 * IDX_BITS;
   localparam int MATRIX_DEPTH = MAX_VERTICES * MAX_VERTICES;

   localparam logic [WEIGHT_BITS-1:0] NO_EDGE     = '1;
   localparam logic [VERT_BITS-1:0]   COUNT_RESET = VERT_BITS'(MAX_VERTICES);

   localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_RUN   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [VERT_BITS-1:0]   end_a;
      logic [VERT_BITS-1:0]   end_b;
      logic [WEIGHT_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [VERT_BITS-1:0]   added_vertex;
      logic [VERT_BITS-1:0]   tree_vertex;
      logic [WEIGHT_BITS-1:0] edge_weight;
      logic                   disconnected;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [VERT_BITS-1:0]   nbr;
      logic [WEIGHT_BITS-1:0] cost;
   } dist_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clr_en;
      logic load_first;
      logic load_second;
      logic run_start;
      logic scan_en;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic load_ok;
      logic run_single;
      logic scan_last;
      logic found;
      logic last_step;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> design/prim_minimum_spanning_tree_core.sv
`default_nettype none
// Load: both symmetric entries written through one port; the next beat waits for both.
// Clear: one matrix entry per cycle; run with n vertices: accept, then per added vertex
// scan of vertices 2..n, drain, emit (stalls on full output), bound by the matrix read port.
// Results wait in an output register while the next pass proceeds.
// Reset: synchronous; a clearing pass over the whole matrix runs first, with req_ready low.
module prim_minimum_spanning_tree_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire pmst_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output pmst_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [pmst_pkg::VERT_BITS-1:0] csr_wr_data
);

   pmst_pkg::cmd_type    cmd;
   pmst_pkg::status_type status;

   pmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   pmst_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

>>> design/pmst_ram.sv
`default_nettype none
module pmst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/pmst_ctrl.sv
`default_nettype none
module pmst_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic [pmst_pkg::FUNC_BITS-1:0] req_func,
   input  wire pmst_pkg::status_type           status,
   output logic                                req_ready,
   output pmst_pkg::cmd_type                   cmd
);

   pmst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         pmst_pkg::ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_done) begin
               state_in = pmst_pkg::ST_IDLE;
            end
         end
         pmst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_func)
                  pmst_pkg::FUNC_LOAD: begin
                     if (status.load_ok) begin
                        cmd.load_first = 1'b1;
                        state_in       = pmst_pkg::ST_LOAD;
                     end
                  end
                  pmst_pkg::FUNC_RUN: begin
                     if (!status.run_single) begin
                        cmd.run_start = 1'b1;
                        state_in      = pmst_pkg::ST_SCAN;
                     end
                  end
                  pmst_pkg::FUNC_CLEAR: begin
                     state_in = pmst_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pmst_pkg::ST_LOAD: begin
            cmd.load_second = 1'b1;
            state_in        = pmst_pkg::ST_IDLE;
         end
         pmst_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_last) begin
               state_in = pmst_pkg::ST_DRAIN;
            end
         end
         pmst_pkg::ST_DRAIN: begin
            state_in = pmst_pkg::ST_EMIT;
         end
         pmst_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (!status.found || status.last_step) begin
                  state_in = pmst_pkg::ST_IDLE;
               end else begin
                  state_in = pmst_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = pmst_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/pmst_dpath.sv
`default_nettype none
`include "prim_minimum_spanning_tree_core_macros.svh"
module pmst_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pmst_pkg::req_type              req_data,
   input  wire logic                           csr_wr_en,
   input  wire logic [pmst_pkg::VERT_BITS-1:0] csr_wr_data,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output pmst_pkg::rsp_type                   rsp_data,
   input  wire pmst_pkg::cmd_type              cmd,
   output pmst_pkg::status_type                status
);

   localparam int IB = pmst_pkg::IDX_BITS;
   localparam int VB = pmst_pkg::VERT_BITS;
   localparam int WB = pmst_pkg::WEIGHT_BITS;
   localparam int AB = pmst_pkg::ADDR_BITS;
   localparam int MV = pmst_pkg::MAX_VERTICES;

   logic [VB-1:0]                  count_ff;
   logic [VB-1:0]                  eff_n;
   logic [VB-1:0]                  n_ff;
   logic [IB-1:0]                  last_idx;
   logic [pmst_pkg::ADDR_BITS-1:0] clr_ff;
   logic [pmst_pkg::MAX_VERTICES-1:0] in_tree_ff;
   logic                           init_ff;
   logic [IB-1:0]                  j_ff;
   logic [IB-1:0]                  pick_ff;
   logic [IB-1:0]                  step_ff;
   logic                           d1_valid_ff;
   logic [IB-1:0]                  d1_idx_ff;
   logic [WB-1:0]                  min_w_ff;
   logic [IB-1:0]                  min_idx_ff;
   logic [VB-1:0]                  min_nbr_ff;
   logic [IB-1:0]                  la_ff;
   logic [IB-1:0]                  lb_ff;
   logic [WB-1:0]                  lw_ff;
   logic                           rsp_valid_ff;
   pmst_pkg::rsp_type              rsp_data_ff;

   logic [IB-1:0]                  a_idx;
   logic [IB-1:0]                  b_idx;
   logic                           w_we;
   logic [pmst_pkg::ADDR_BITS-1:0] w_waddr;
   logic [WB-1:0]                  w_wdata;
   logic [pmst_pkg::ADDR_BITS-1:0] w_raddr;
   logic [WB-1:0]                  w_rdata;
   logic                           d_we;
   pmst_pkg::dist_type             d_wdata;
   pmst_pkg::dist_type             d_rdata;
   logic                           cur_in;
   logic                           upd;
   logic                           cand;

   assign a_idx    = IB'(req_data.end_a - VB'(1));
   assign b_idx    = IB'(req_data.end_b - VB'(1));
   assign last_idx = IB'(n_ff - VB'(1));

   always_comb begin
      if (count_ff == '0) begin
         eff_n = VB'(1);
      end else if (count_ff > VB'(pmst_pkg::MAX_VERTICES)) begin
         eff_n = VB'(pmst_pkg::MAX_VERTICES);
      end else begin
         eff_n = count_ff;
      end
   end

   // matrix write port: clearing sweep, then the two halves of an edge
   always_comb begin
      w_we    = 1'b0;
      w_waddr = clr_ff;
      w_wdata = pmst_pkg::NO_EDGE;
      if (cmd.clr_en) begin
         w_we = 1'b1;
      end else if (cmd.load_first) begin
         w_we    = 1'b1;
         w_waddr = {a_idx, b_idx};
         w_wdata = req_data.weight;
      end else if (cmd.load_second) begin
         w_we    = 1'b1;
         w_waddr = {lb_ff, la_ff};
         w_wdata = lw_ff;
      end
   end

   assign w_raddr = init_ff ? {IB'(0), j_ff} : {j_ff, pick_ff};

   pmst_ram #(
      .WIDTH (WB),
      .DEPTH (pmst_pkg::MATRIX_DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   // relax one vertex per cycle while scanning and track the running minimum
   always_comb begin
      cur_in = in_tree_ff[d1_idx_ff];
      upd    = !cur_in && (w_rdata < d_rdata.cost);
      if (init_ff) begin
         d_wdata.nbr  = VB'(1);
         d_wdata.cost = w_rdata;
         d_we         = d1_valid_ff;
      end else begin
         d_wdata.nbr  = upd ? VB'(pick_ff) + VB'(1) : d_rdata.nbr;
         d_wdata.cost = upd ? w_rdata : d_rdata.cost;
         d_we         = d1_valid_ff && upd;
      end
      cand = d1_valid_ff && !cur_in && (d_wdata.cost < min_w_ff);
   end

   pmst_ram #(
      .WIDTH ($bits(pmst_pkg::dist_type)),
      .DEPTH (pmst_pkg::MAX_VERTICES)
   ) u_best (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d1_idx_ff),
      .wr_data (d_wdata),
      .rd_addr (j_ff),
      .rd_data (d_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= pmst_pkg::COUNT_RESET;
         clr_ff       <= '0;
         in_tree_ff   <= '0;
         d1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + AB'(1);
         end
         if (cmd.run_start) begin
            in_tree_ff <= MV'(1);
         end else if (cmd.emit && status.found) begin
            in_tree_ff[min_idx_ff] <= 1'b1;
         end
         d1_valid_ff <= cmd.scan_en;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      d1_idx_ff <= j_ff;
      if (cmd.load_first) begin
         la_ff <= a_idx;
         lb_ff <= b_idx;
         lw_ff <= req_data.weight;
      end
      if (cmd.run_start) begin
         n_ff     <= eff_n;
         init_ff  <= 1'b1;
         step_ff  <= IB'(1);
         j_ff     <= IB'(1);
         min_w_ff <= pmst_pkg::NO_EDGE;
      end
      if (cmd.scan_en && !status.scan_last) begin
         j_ff <= j_ff + IB'(1);
      end
      if (cand) begin
         min_w_ff   <= d_wdata.cost;
         min_idx_ff <= d1_idx_ff;
         min_nbr_ff <= d_wdata.nbr;
      end
      if (cmd.emit) begin
         init_ff  <= 1'b0;
         pick_ff  <= min_idx_ff;
         step_ff  <= step_ff + IB'(1);
         j_ff     <= IB'(1);
         min_w_ff <= pmst_pkg::NO_EDGE;
         if (status.found) begin
            rsp_data_ff.added_vertex <= VB'(min_idx_ff) + VB'(1);
            rsp_data_ff.tree_vertex  <= min_nbr_ff;
            rsp_data_ff.edge_weight  <= min_w_ff;
            rsp_data_ff.disconnected <= 1'b0;
            rsp_data_ff.last         <= status.last_step;
         end else begin
            rsp_data_ff.added_vertex <= '0;
            rsp_data_ff.tree_vertex  <= '0;
            rsp_data_ff.edge_weight  <= '0;
            rsp_data_ff.disconnected <= 1'b1;
            rsp_data_ff.last         <= 1'b1;
         end
      end
   end

   always_comb begin
      status.clr_done   = (clr_ff == '1);
      status.load_ok    = (req_data.end_a != '0)
                          && (req_data.end_a <= VB'(pmst_pkg::MAX_VERTICES))
                          && (req_data.end_b != '0)
                          && (req_data.end_b <= VB'(pmst_pkg::MAX_VERTICES));
      status.run_single = (eff_n == VB'(1));
      status.scan_last  = (j_ff == last_idx);
      status.found      = (min_w_ff != pmst_pkg::NO_EDGE);
      status.last_step  = (step_ff == last_idx);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PMST_ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)
   `PMST_ASSERT_IMPLY(a_emit_no_read, clock, reset, cmd.emit, !d1_valid_ff && in_tree_ff[0])
   `PMST_ASSERT_IMPLY(a_scan_index, clock, reset, cmd.scan_en, j_ff != '0 && !init_ff || j_ff != '0)
   `PMST_ASSERT_IMPLY(a_disc_last, clock, reset, rsp_valid_ff && rsp_data_ff.disconnected, rsp_data_ff.last)

endmodule
`default_nettype wire
